FILE: sv/potl_pkg.sv
`timescale 1ns / 1ps

package potl_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int MODE_W  = 3;
    localparam int ID_W    = 16;
    localparam int PRI_W   = 8;
    localparam int STAT_W  = 2;
    localparam int OCNT_W  = 6;

    // request modes
    localparam logic [MODE_W-1:0] M_FRONT    = 3'd0;
    localparam logic [MODE_W-1:0] M_BACK     = 3'd1;
    localparam logic [MODE_W-1:0] M_PRIO     = 3'd2;
    localparam logic [MODE_W-1:0] M_REMOVE   = 3'd3;
    localparam logic [MODE_W-1:0] M_COMPLETE = 3'd4;

    // result status
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_REM  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

FILE: sv/priority_ordered_task_list.sv
`timescale 1ns / 1ps
// channel   valid        ready        payload
// request   i_in_valid   o_in_ready   i_mode, i_task_id, i_priority_req
// result    o_out_valid  i_out_ready  o_status, o_entry_count, o_done_valid,
//                                     o_done_id, o_done_priority
//
// an insert or remove makes one pass over all entries held in the entry memory,
// one entry per cycle on its single read port
// a full-list insert or an unused mode skips the pass and goes straight to the result
// reset clears the count and control only; entries are never read before written
// a new request beat is taken while an earlier result still waits on the output
// a result that finds the output register full holds the block until it drains

module priority_ordered_task_list #(
    parameter int CAPACITY = potl_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [potl_pkg::MODE_W-1:0] i_mode,
    input  logic [potl_pkg::ID_W-1:0]   i_task_id,
    input  logic [potl_pkg::PRI_W-1:0]  i_priority_req,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [potl_pkg::STAT_W-1:0] o_status,
    output logic [potl_pkg::OCNT_W-1:0] o_entry_count,
    output logic                        o_done_valid,
    output logic [potl_pkg::ID_W-1:0]   o_done_id,
    output logic [potl_pkg::PRI_W-1:0]  o_done_priority
);

    import potl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_entry             r_mem [CAPACITY];
    t_entry             r_rd_data;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    t_entry             mem_wdata;
    logic [AW-1:0]      mem_raddr;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_k, n_k;
    logic [MODE_W-1:0]  r_mode, n_mode;
    logic [ID_W-1:0]    r_id, n_id;
    t_entry             r_carry, n_carry;
    logic               r_found, n_found;
    logic [STAT_W-1:0]  r_status, n_status;
    logic               r_dv, n_dv;
    logic [ID_W-1:0]    r_did, n_did;
    logic [PRI_W-1:0]   r_dpri, n_dpri;

    logic               r_out_valid, n_out_valid;
    logic [STAT_W-1:0]  r_out_status, n_out_status;
    logic [OCNT_W-1:0]  r_out_count, n_out_count;
    logic               r_out_dv, n_out_dv;
    logic [ID_W-1:0]    r_out_did, n_out_did;
    logic [PRI_W-1:0]   r_out_dpri, n_out_dpri;

    logic               at_end;
    logic               hit;

    // entry memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    assign mem_raddr  = (r_state == S_IDLE) ? '0 : AW'(r_k + 1'b1);
    assign at_end     = (r_k == r_count);
    assign hit        = r_found || at_end || (r_mode == M_FRONT) ||
                        ((r_mode == M_PRIO) && (r_rd_data.pri < r_carry.pri));
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_k          = r_k;
        n_mode       = r_mode;
        n_id         = r_id;
        n_carry      = r_carry;
        n_found      = r_found;
        n_status     = r_status;
        n_dv         = r_dv;
        n_did        = r_did;
        n_dpri       = r_dpri;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_dv     = r_out_dv;
        n_out_did    = r_out_did;
        n_out_dpri   = r_out_dpri;
        mem_we       = 1'b0;
        mem_waddr    = r_k[AW-1:0];
        mem_wdata    = r_carry;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode   = i_mode;
                    n_id     = i_task_id;
                    n_carry  = '{id: i_task_id, pri: i_priority_req};
                    n_k      = '0;
                    n_found  = 1'b0;
                    n_status = ST_OK;
                    n_dv     = 1'b0;
                    n_did    = '0;
                    n_dpri   = '0;
                    case (i_mode) inside
                        M_FRONT, M_BACK, M_PRIO: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state  = S_INS;
                            end
                        end
                        M_REMOVE, M_COMPLETE: begin
                            n_state = S_REM;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_INS: begin
                // once placed, each read entry rides one slot back via the carry
                if (hit) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_k[AW-1:0];
                    mem_wdata = r_carry;
                    n_carry   = r_rd_data;
                    n_found   = 1'b1;
                end
                if (at_end) begin
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_REM: begin
                if (at_end) begin
                    if (r_found) begin
                        n_count = r_count - 1'b1;
                    end else begin
                        n_status = ST_NOTFOUND;
                    end
                    n_state = S_DONE;
                end else begin
                    if (r_found) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(r_k - 1'b1);
                        mem_wdata = r_rd_data;
                    end else if (r_rd_data.id == r_id) begin
                        n_found = 1'b1;
                        if (r_mode == M_COMPLETE) begin
                            n_dv   = 1'b1;
                            n_did  = r_rd_data.id;
                            n_dpri = r_rd_data.pri;
                        end
                    end
                    n_k = r_k + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_count  = OCNT_W'(r_count);
                    n_out_dv     = r_dv;
                    n_out_did    = r_did;
                    n_out_dpri   = r_dpri;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k          <= n_k;
        r_mode       <= n_mode;
        r_id         <= n_id;
        r_carry      <= n_carry;
        r_found      <= n_found;
        r_status     <= n_status;
        r_dv         <= n_dv;
        r_did        <= n_did;
        r_dpri       <= n_dpri;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_dv     <= n_out_dv;
        r_out_did    <= n_out_did;
        r_out_dpri   <= n_out_dpri;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_entry_count   = r_out_count;
    assign o_done_valid    = r_out_dv;
    assign o_done_id       = r_out_did;
    assign o_done_priority = r_out_dpri;

`ifndef SYNTH
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS || r_state == S_REM) |-> (r_k <= r_count))
        else $error("scan index past entry count");

    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REM && r_found) |-> (r_k != '0))
        else $error("remove shift below first entry");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
        ($past(r_state == S_INS) || $past(r_state == S_REM)))
        else $error("entry count changed outside a scan");

    a_done_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_valid) |-> (o_status == ST_OK))
        else $error("completed task reported with error status");
`endif

endmodule

FILE: test/priority_ordered_task_list_tb.sv
`timescale 1ns / 1ps

module priority_ordered_task_list_tb;
    import potl_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int N_ITEMS     = 1450;
    localparam int TAIL_ITEMS  = 120;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_PRINTS  = 60;

    localparam logic [MODE_W-1:0] M_SPARE_LO = M_COMPLETE + 1'b1;
    localparam logic [MODE_W-1:0] M_SPARE_HI = {MODE_W{1'b1}};

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   id;
        logic [PRI_W-1:0]  pri;
        bit                drain;
    } t_request;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OCNT_W-1:0] count;
        logic              done_valid;
        logic [ID_W-1:0]   done_id;
        logic [PRI_W-1:0]  done_pri;
    } t_result;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic [MODE_W-1:0] i_mode         = '0;
    logic [ID_W-1:0]   i_task_id      = '0;
    logic [PRI_W-1:0]  i_priority_req = '0;
    logic              i_out_ready    = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [STAT_W-1:0] o_status;
    logic [OCNT_W-1:0] o_entry_count;
    logic              o_done_valid;
    logic [ID_W-1:0]   o_done_id;
    logic [PRI_W-1:0]  o_done_priority;

    t_entry           task_list[$];
    logic [ID_W-1:0]  planned_ids[$];
    t_request         request_q[$];
    t_result          result_q[$];

    int errors     = 0;
    int beats_in   = 0;
    int beats_out  = 0;
    int send_gap   = 0;
    int recv_stall = 0;
    int cycles     = 0;

    priority_ordered_task_list #(.CAPACITY(CAPACITY)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_task_id      (i_task_id),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_done_valid   (o_done_valid),
        .o_done_id      (o_done_id),
        .o_done_priority(o_done_priority)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // list update for one accepted request
    function automatic t_result apply_request(input logic [MODE_W-1:0] mode,
                                              input logic [ID_W-1:0] id,
                                              input logic [PRI_W-1:0] pri);
        t_result r;
        t_entry  e;
        int      pos;
        r     = '0;
        e.id  = id;
        e.pri = pri;
        pos   = 0;
        case (mode)
            M_FRONT, M_BACK, M_PRIO: begin
                if (task_list.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (mode == M_FRONT) begin
                    task_list.push_front(e);
                end else if (mode == M_BACK) begin
                    task_list.push_back(e);
                end else begin
                    // after every entry of greater or equal priority
                    while (pos < task_list.size() && task_list[pos].pri >= pri) pos++;
                    task_list.insert(pos, e);
                end
            end
            M_REMOVE, M_COMPLETE: begin
                while (pos < task_list.size() && task_list[pos].id != id) pos++;
                if (pos >= task_list.size()) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    if (mode == M_COMPLETE) begin
                        r.done_valid = 1'b1;
                        r.done_id    = task_list[pos].id;
                        r.done_pri   = task_list[pos].pri;
                    end
                    task_list.delete(pos);
                end
            end
            default: begin
            end
        endcase
        r.count = OCNT_W'(task_list.size());
        return r;
    endfunction

    // queues a request and tracks which ids will be held once it is done
    function automatic void plan_request(input logic [MODE_W-1:0] mode,
                                         input logic [ID_W-1:0] id,
                                         input logic [PRI_W-1:0] pri,
                                         input bit drain);
        t_request rq;
        int       pos;
        rq.mode  = mode;
        rq.id    = id;
        rq.pri   = pri;
        rq.drain = drain;
        pos      = 0;
        request_q.push_back(rq);
        if (mode == M_FRONT || mode == M_BACK || mode == M_PRIO) begin
            if (planned_ids.size() < CAPACITY) planned_ids.push_back(id);
        end else if (mode == M_REMOVE || mode == M_COMPLETE) begin
            while (pos < planned_ids.size() && planned_ids[pos] != id) pos++;
            if (pos < planned_ids.size()) planned_ids.delete(pos);
        end
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return ID_W'($urandom_range(0, 15));
            default: return ID_W'($urandom);
        endcase
    endfunction

    // tie-heavy priorities
    function automatic logic [PRI_W-1:0] pick_pri();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return PRI_W'($urandom_range(126, 129));
            3:       return PRI_W'($urandom_range(0, 3));
            default: return PRI_W'($urandom);
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_insert();
        case ($urandom_range(0, 2))
            0:       return M_FRONT;
            1:       return M_BACK;
            default: return M_PRIO;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_take();
        return ($urandom_range(0, 1) != 0) ? M_REMOVE : M_COMPLETE;
    endfunction

    // idle-free windows, and none near the end
    function automatic bit idle_ok(input int beats, input int left);
        return ((beats / 100) % 3 != 1) && (left > TAIL_ITEMS);
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= MAX_PRINTS) $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("beat %0d %s got %0h expected %0h",
                                 beats_out, name, got, want));
    endtask

    always @(posedge i_clk) begin : drive_req
        t_request nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                result_q.push_back(apply_request(i_mode, i_task_id, i_priority_req));
                beats_in++;
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (request_q.size() == 0 ||
                             (request_q[0].drain && result_q.size() != 0)) begin
                    i_in_valid <= 1'b0;
                end else if (idle_ok(beats_in, request_q.size()) &&
                             $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 14);
                    i_in_valid <= 1'b0;
                end else begin
                    nxt = request_q.pop_front();
                    i_in_valid     <= 1'b1;
                    i_mode         <= nxt.mode;
                    i_task_id      <= nxt.id;
                    i_priority_req <= nxt.pri;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_result
        t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                beats_out++;
                if (result_q.size() == 0) begin
                    flag_error($sformatf("beat %0d with no request pending", beats_out));
                end else begin
                    want = result_q.pop_front();
                    check_field("status", 32'(o_status), 32'(want.status));
                    check_field("entry_count", 32'(o_entry_count), 32'(want.count));
                    check_field("done_valid", 32'(o_done_valid), 32'(want.done_valid));
                    check_field("done_id", 32'(o_done_id), 32'(want.done_id));
                    check_field("done_priority", 32'(o_done_priority),
                                32'(want.done_pri));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                i_out_ready <= 1'b0;
            end else if (idle_ok(beats_out, request_q.size()) &&
                         $urandom_range(0, 5) == 0) begin
                recv_stall = $urandom_range(0, 14);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int  sel;
        bit  first;
        // empty list: misses and unused modes
        plan_request(M_REMOVE, '0, '0, 1'b0);
        plan_request(M_COMPLETE, '1, '1, 1'b0);
        plan_request(M_SPARE_LO, ID_W'($urandom), PRI_W'($urandom), 1'b0);
        plan_request(M_SPARE_LO + 1'b1, ID_W'($urandom), PRI_W'($urandom), 1'b0);
        plan_request(M_SPARE_HI, ID_W'($urandom), PRI_W'($urandom), 1'b0);
        // every insert mode, ties and duplicate ids, then removes, completes and misses
        plan_request(M_FRONT, 16'h1234, '0, 1'b0);
        plan_request(M_BACK, '1, '1, 1'b0);
        plan_request(M_PRIO, '0, 8'h80, 1'b0);
        plan_request(M_PRIO, 16'h0001, 8'h80, 1'b0);
        plan_request(M_PRIO, 16'h0002, '0, 1'b0);
        plan_request(M_PRIO, 16'hAAAA, '1, 1'b0);
        plan_request(M_FRONT, 16'h1234, 8'h55, 1'b0);
        plan_request(M_BACK, 16'h5555, 8'hAA, 1'b0);
        plan_request(M_COMPLETE, 16'h1234, '0, 1'b0);
        plan_request(M_REMOVE, '0, '1, 1'b0);
        plan_request(M_COMPLETE, '1, '0, 1'b0);
        plan_request(M_SPARE_HI, 16'h1234, '1, 1'b0);
        plan_request(M_REMOVE, 16'h7777, '0, 1'b0);
        plan_request(M_COMPLETE, 16'h1234, '0, 1'b0);
        plan_request(M_COMPLETE, 16'h1234, '0, 1'b0);

        while (request_q.size() < N_ITEMS) begin
            sel = $urandom_range(0, 3);
            if (request_q.size() < 40) sel = 0;
            case (sel)
                0: begin
                    // fill to capacity, then hit the full list with each insert
                    first = 1'b1;
                    while (planned_ids.size() < CAPACITY) begin
                        plan_request(pick_insert(), pick_id(), pick_pri(), first);
                        first = 1'b0;
                    end
                    plan_request(M_FRONT, pick_id(), pick_pri(), first);
                    plan_request(M_BACK, pick_id(), pick_pri(), 1'b0);
                    plan_request(M_PRIO, pick_id(), pick_pri(), 1'b0);
                end
                1: begin
                    while (planned_ids.size() > 0)
                        plan_request(pick_take(),
                                     planned_ids[$urandom_range(0, planned_ids.size() - 1)],
                                     PRI_W'($urandom), 1'b0);
                    plan_request(pick_take(), pick_id(), PRI_W'($urandom), 1'b0);
                end
                default: begin
                    repeat (40) begin
                        sel = $urandom_range(0, 19);
                        if (sel < 9)
                            plan_request(pick_insert(), pick_id(), pick_pri(), 1'b0);
                        else if (sel < 17 && planned_ids.size() > 0)
                            plan_request(pick_take(),
                                         planned_ids[$urandom_range(0, planned_ids.size() - 1)],
                                         PRI_W'($urandom), 1'b0);
                        else if (sel < 19)
                            plan_request(pick_take(), pick_id(), PRI_W'($urandom), 1'b0);
                        else
                            plan_request(MODE_W'($urandom_range(M_SPARE_LO, M_SPARE_HI)),
                                         ID_W'($urandom), PRI_W'($urandom), 1'b0);
                    end
                end
            endcase
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || result_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/potl_pkg.sv
sv/priority_ordered_task_list.sv
test/priority_ordered_task_list_tb.sv
